// File: design/frb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frb_pkg
// Shared types and constants of the flow record batcher.
// ----------------------------------------------------------------------------
package frb_pkg;

	// APB register map: register i at byte address 4*i
	localparam int unsigned APB_AW = 4;
	localparam logic [1:0] REG_NET_MASK  = 2'd0;
	localparam logic [1:0] REG_NET_BASE  = 2'd1;
	localparam logic [1:0] REG_FLUSH_IVL = 2'd2;

	localparam logic [31:0] NET_MASK_RST  = 32'hFFFF_0000;
	localparam logic [31:0] NET_BASE_RST  = 32'h0000_0000;
	localparam logic [15:0] FLUSH_IVL_RST = 16'd41;
	localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	localparam logic [1:0] DIR_OUTGOING = 2'd0;
	localparam logic [1:0] DIR_INCOMING = 2'd1;
	localparam logic [1:0] DIR_NEITHER  = 2'd2;

	localparam logic [1:0] CLS_TCP   = 2'd0;
	localparam logic [1:0] CLS_UDP   = 2'd1;
	localparam logic [1:0] CLS_OTHER = 2'd2;

	// One stored flow record, 52 bits
	typedef struct packed {
		logic [31:0] host;
		logic [1:0]  dir;
		logic [1:0]  cls;
		logic [15:0] size;
	} rec_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

// File: design/frb_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frb_classify
// Builds a flow record from a packet summary and the local subnet settings.
// ----------------------------------------------------------------------------
module frb_classify import frb_pkg::*; (
	input  logic [15:0] eth_type,
	input  logic [7:0]  ip_proto,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] packet_length,
	input  logic [31:0] net_mask,
	input  logic [31:0] net_base,
	output logic        is_ip,
	output rec_t        rec
);

	logic src_local;
	logic dst_local;

	assign is_ip     = (eth_type == ETHERTYPE_IPV4);
	assign src_local = ((src_addr & net_mask) == net_base);
	assign dst_local = ((dst_addr & net_mask) == net_base);

	always_comb begin
		rec.size = packet_length;
		// source wins when both sides are local
		if (src_local) begin
			rec.dir  = DIR_OUTGOING;
			rec.host = src_addr & ~net_mask;
		end else if (dst_local) begin
			rec.dir  = DIR_INCOMING;
			rec.host = dst_addr & ~net_mask;
		end else begin
			rec.dir  = DIR_NEITHER;
			rec.host = '0;
		end
		case (ip_proto)
			PROTO_TCP: rec.cls = CLS_TCP;
			PROTO_UDP: rec.cls = CLS_UDP;
			default:   rec.cls = CLS_OTHER;
		endcase
	end

endmodule

// File: design/frb_rec_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frb_rec_mem
// Record store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module frb_rec_mem import frb_pkg::*; #(
	parameter int unsigned DEPTH  = 32,
	parameter int unsigned ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  rec_t              wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output rec_t              rdata
);

	rec_t mem [0:DEPTH-1];
	rec_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/flow_record_batcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_record_batcher
// Classifies IPv4 packet summaries into flow records, batches them in a
// record store and drains the batch when it fills or when an IP packet arrives after the tick timer expired.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid/in_ready  | kind eth_type ip_proto src_addr
//           |                    | dst_addr packet_length
//   out     | out_valid/out_ready| host_addr direction proto_class
//           |                    | packet_size last
//   cfg     | APB psel/penable   | paddr pwrite pwdata prdata pready
//
// Flow: in_ready is high whenever no flush is running. A flush reads each
// record from the record store, then loads it into the output register; a
// new read is issued only once the data of the previous read has landed,
// as the store has a single read port with registered read data.
// Reset: count cleared, tick timer set to all ones so the first packet
// flushes, registers to their defaults. No clearing pass: the store is only
// read at entries written in the current batch.
// Stalls: out_ready low holds the output register and pauses store reads;
// in_ready stays low until the last read of a flush has been issued.
// ----------------------------------------------------------------------------
module flow_record_batcher import frb_pkg::*; #(
	parameter int unsigned BATCH_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// input items
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [15:0]       eth_type,
	input  logic [7:0]        ip_proto,
	input  logic [31:0]       src_addr,
	input  logic [31:0]       dst_addr,
	input  logic [15:0]       packet_length,
	// result items
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       host_addr,
	output logic [1:0]        direction,
	output logic [1:0]        proto_class,
	output logic [15:0]       packet_size,
	output logic              last,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// count must hold BATCH_DEPTH itself; the store index only DEPTH-1
	localparam int unsigned CNT_W  = $clog2(BATCH_DEPTH + 1);
	localparam int unsigned ADDR_W = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BATCH_DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	// configuration registers
	logic [31:0] net_mask_q;
	logic [31:0] net_base_q;
	logic [15:0] flush_ivl_q;

	// batch control
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_inc;
	logic [15:0]      elapsed_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] drain_len_q;

	// read pipeline and output register
	logic rd_s1;
	logic last_s1;
	logic out_valid_q;
	logic out_last_q;
	rec_t out_rec_q;

	// item decode
	logic in_acc;
	logic tick_acc;
	logic pkt_wr;
	logic flush_go;
	logic rd_go;
	logic rd_last;
	logic is_ip;
	rec_t new_rec;
	rec_t rd_rec;
	logic cfg_wr;

	// ------------------------------------------------------------------
	// Configuration port: write in the access phase, read any time
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_mask_q  <= NET_MASK_RST;
			net_base_q  <= NET_BASE_RST;
			flush_ivl_q <= FLUSH_IVL_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_NET_MASK:  net_mask_q  <= pwdata;
				REG_NET_BASE:  net_base_q  <= pwdata;
				REG_FLUSH_IVL: flush_ivl_q <= pwdata[15:0];
				default: ;  // unmapped: drop the write
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NET_MASK:  prdata = net_mask_q;
			REG_NET_BASE:  prdata = net_base_q;
			REG_FLUSH_IVL: prdata = {16'd0, flush_ivl_q};
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Record build
	// ------------------------------------------------------------------
	frb_classify u_classify (
		.eth_type      (eth_type),
		.ip_proto      (ip_proto),
		.src_addr      (src_addr),
		.dst_addr      (dst_addr),
		.packet_length (packet_length),
		.net_mask      (net_mask_q),
		.net_base      (net_base_q),
		.is_ip         (is_ip),
		.rec           (new_rec)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign tick_acc  = in_acc & kind;
	assign pkt_wr    = in_acc & ~kind & is_ip;
	assign count_inc = count_q + ONE_C;
	// flush once the appended record fills the batch or the timer ran out
	assign flush_go  = pkt_wr & ((count_inc == DEPTH_C) | (elapsed_q > flush_ivl_q));

	// ------------------------------------------------------------------
	// Drain: issue a read only when the output register will be free
	// by the time the read data lands
	// ------------------------------------------------------------------
	assign rd_go   = (state_q == ST_DRAIN) & ~rd_s1 & (~out_valid_q | out_ready);
	assign rd_last = (rd_ptr_q == (drain_len_q - ONE_C));

	frb_rec_mem #(
		.DEPTH  (BATCH_DEPTH),
		.ADDR_W (ADDR_W)
	) u_rec_mem (
		.clk   (clk),
		.we    (pkt_wr),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (new_rec),
		.re    (rd_go),
		.raddr (rd_ptr_q[ADDR_W-1:0]),
		.rdata (rd_rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (flush_go) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (rd_go && rd_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// batch count, tick timer and drain pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			elapsed_q   <= TICKS_MAX;
			rd_ptr_q    <= '0;
			drain_len_q <= '0;
		end else begin
			if (flush_go) begin
				count_q     <= '0;
				elapsed_q   <= '0;
				rd_ptr_q    <= '0;
				drain_len_q <= count_inc;
			end else begin
				if (pkt_wr) begin
					count_q <= count_inc;
				end
				// saturate at all ones
				if (tick_acc && elapsed_q != TICKS_MAX) begin
					elapsed_q <= elapsed_q + 16'd1;
				end
				if (rd_go) begin
					rd_ptr_q <= rd_ptr_q + ONE_C;
				end
			end
		end
	end

	// read pipeline valid and last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1   <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			rd_s1   <= rd_go;
			last_s1 <= rd_go & rd_last;
		end
	end

	// output register: load when read data lands, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (rd_s1) begin
			out_valid_q <= 1'b1;
			out_last_q  <= last_s1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1) begin
			out_rec_q <= rd_rec;
		end
	end

	assign out_valid   = out_valid_q;
	assign host_addr   = out_rec_q.host;
	assign direction   = out_rec_q.dir;
	assign proto_class = out_rec_q.cls;
	assign packet_size = out_rec_q.size;
	assign last        = out_last_q;

`ifndef ASSERT_OFF
	a_out_free_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> !out_valid_q)
		else $error("read data landed on an occupied output register");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < DEPTH_C)
		else $error("batch count reached the store depth");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		flush_go |=> (state_q == ST_DRAIN) && (count_q == '0) && (elapsed_q == '0))
		else $error("flush did not clear count and timer");

	a_drain_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (rd_ptr_q < drain_len_q))
		else $error("drain pointer ran past the batch");

	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rd_go |-> !pkt_wr)
		else $error("store write during a drain");
`endif

endmodule
